// File: rtl/core/smcp_pkg.sv
// Shared types, reset values and the CRC-8 step for the SPI motor command parser.
// No dependencies; imported by the parser top level and its checker.
package smcp_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 3;
    localparam int MOTOR_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_CODE     = 3'd0,
        CFG_IDLE_CODE     = 3'd1,
        CFG_VERSION_CODE  = 3'd2,
        CFG_MOTOR_CODE    = 3'd3,
        CFG_VERSION_REPLY = 3'd4
    } cfg_index_t;

    // Register reset values
    localparam logic [BYTE_W-1:0] SYNC_CODE_RST     = 8'h80;
    localparam logic [BYTE_W-1:0] IDLE_CODE_RST     = 8'h00;
    localparam logic [BYTE_W-1:0] VERSION_CODE_RST  = 8'h01;
    localparam logic [BYTE_W-1:0] MOTOR_CODE_RST    = 8'h02;
    localparam logic [BYTE_W-1:0] VERSION_REPLY_RST = 8'h01;

    // Reply to an unknown command
    localparam logic [BYTE_W-1:0] UNKNOWN_REPLY = 8'h00;

    // Payload bytes in a motor-set command; at this position the check byte is due
    localparam logic [POS_W-1:0] PAYLOAD_LEN = 3'd4;

    // Dallas/Maxim CRC-8, reflected form
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

    function automatic logic [BYTE_W-1:0] crc8_fold(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] v;
        v = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

// File: rtl/core/spi_motor_command_parser.sv
// SPI motor command parser: sync/command/payload/CRC-8 check in one registered pass.
// Depends on smcp_pkg (register indexes, reset values, crc8_fold).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_rx_byte
//  m_      | out       | m_valid / m_ready  | m_reply_valid, m_reply_byte, m_motor_valid,
//          |           |                    | m_motor_a, m_motor_b
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Every accepted byte yields exactly one result transaction in the cycle after acceptance.
// Throughput is one byte per cycle while m_ready is high: the CRC-8 step and the parser
// decision sit in one combinational pass between parser state and result register.
// s_ready drops only while a result waits in the result register and m_ready is low.
// aresetn is synchronous, active low; it clears the command, position and CRC state, the
// result valid and all configuration registers. cfg_ready is always high.
module spi_motor_command_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    // received byte stream
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [smcp_pkg::BYTE_W-1:0]  s_rx_byte,
    // result stream
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_reply_valid,
    output logic        [smcp_pkg::BYTE_W-1:0]  m_reply_byte,
    output logic                                m_motor_valid,
    output logic signed [smcp_pkg::MOTOR_W-1:0] m_motor_a,
    output logic signed [smcp_pkg::MOTOR_W-1:0] m_motor_b,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [smcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [smcp_pkg::BYTE_W-1:0]  cfg_data
);
    import smcp_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] sync_code_reg;
    logic [BYTE_W-1:0] idle_code_reg;
    logic [BYTE_W-1:0] version_code_reg;
    logic [BYTE_W-1:0] motor_code_reg;
    logic [BYTE_W-1:0] version_reply_reg;

    // parser state
    logic [BYTE_W-1:0] active_command_reg, active_command_next;
    logic [POS_W-1:0]  byte_position_reg,  byte_position_next;
    logic [BYTE_W-1:0] running_crc_reg,    running_crc_next;
    logic [BYTE_W-1:0] payload_reg [PAYLOAD_LEN];
    logic              payload_we;

    // result register
    logic                      m_valid_reg;
    logic                      reply_valid_reg, reply_valid_next;
    logic [BYTE_W-1:0]         reply_byte_reg,  reply_byte_next;
    logic                      motor_valid_reg, motor_valid_next;
    logic signed [MOTOR_W-1:0] motor_a_reg,     motor_a_next;
    logic signed [MOTOR_W-1:0] motor_b_reg,     motor_b_next;

    logic s_accept;

    // Take a new byte whenever the result register is empty or drains this cycle.
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_code_reg     <= SYNC_CODE_RST;
            idle_code_reg     <= IDLE_CODE_RST;
            version_code_reg  <= VERSION_CODE_RST;
            motor_code_reg    <= MOTOR_CODE_RST;
            version_reply_reg <= VERSION_REPLY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_SYNC_CODE:     sync_code_reg     <= cfg_data;
                CFG_IDLE_CODE:     idle_code_reg     <= cfg_data;
                CFG_VERSION_CODE:  version_code_reg  <= cfg_data;
                CFG_MOTOR_CODE:    motor_code_reg    <= cfg_data;
                CFG_VERSION_REPLY: version_reply_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Parser step. Decode priority when codes collide: idle, version, motor, unknown.
    always_comb begin
        active_command_next = active_command_reg;
        byte_position_next  = byte_position_reg;
        running_crc_next    = running_crc_reg;
        payload_we          = 1'b0;
        reply_valid_next    = 1'b0;
        reply_byte_next     = '0;
        motor_valid_next    = 1'b0;
        motor_a_next        = '0;
        motor_b_next        = '0;

        if (active_command_reg == idle_code_reg) begin
            if (byte_position_reg == '0) begin
                // hunt for the sync byte, ignore everything else silently
                if (s_rx_byte == sync_code_reg) begin
                    byte_position_next = POS_W'(1);
                end
            end else begin
                // command byte seeds the CRC; an idle command leaves the parser idle
                active_command_next = s_rx_byte;
                byte_position_next  = '0;
                running_crc_next    = crc8_fold('0, s_rx_byte);
            end
        end else if (active_command_reg == version_code_reg) begin
            reply_valid_next    = 1'b1;
            reply_byte_next     = version_reply_reg;
            active_command_next = idle_code_reg;
            byte_position_next  = '0;
        end else if (active_command_reg == motor_code_reg) begin
            if (byte_position_reg < PAYLOAD_LEN) begin
                // store, echo and fold a payload byte
                payload_we         = 1'b1;
                byte_position_next = byte_position_reg + POS_W'(1);
                running_crc_next   = crc8_fold(running_crc_reg, s_rx_byte);
                reply_valid_next   = 1'b1;
                reply_byte_next    = s_rx_byte;
            end else if (s_rx_byte == running_crc_reg) begin
                // check byte matches: release both motor values, big-endian
                motor_valid_next    = 1'b1;
                motor_a_next        = {payload_reg[0], payload_reg[1]};
                motor_b_next        = {payload_reg[2], payload_reg[3]};
                active_command_next = idle_code_reg;
                byte_position_next  = '0;
            end
            // a mismatching check byte is dropped; keep waiting for the right one
        end else begin
            // unknown command: answer the next byte with zero and go idle
            reply_valid_next    = 1'b1;
            reply_byte_next     = UNKNOWN_REPLY;
            active_command_next = idle_code_reg;
            byte_position_next  = '0;
        end
    end

    // Parser state advances only on an accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_command_reg <= IDLE_CODE_RST;
            byte_position_reg  <= '0;
            running_crc_reg    <= '0;
        end else if (s_accept) begin
            active_command_reg <= active_command_next;
            byte_position_reg  <= byte_position_next;
            running_crc_reg    <= running_crc_next;
        end
    end

    // Payload bytes: no reset, written in order by position.
    always_ff @(posedge aclk) begin
        if (s_accept && payload_we) begin
            payload_reg[byte_position_reg[1:0]] <= s_rx_byte;
        end
    end

    // Result register: load on accept, clear valid once the result is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            reply_valid_reg <= reply_valid_next;
            reply_byte_reg  <= reply_byte_next;
            motor_valid_reg <= motor_valid_next;
            motor_a_reg     <= motor_a_next;
            motor_b_reg     <= motor_b_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reply_valid = reply_valid_reg;
    assign m_reply_byte  = reply_byte_reg;
    assign m_motor_valid = motor_valid_reg;
    assign m_motor_a     = motor_a_reg;
    assign m_motor_b     = motor_b_reg;

endmodule

// File: rtl/core/smcp_checker.sv
// Port-level checks for the SPI motor command parser, bound to its top level.
// Depends on smcp_pkg for widths.
module smcp_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic                                  m_reply_valid,
    input logic        [smcp_pkg::BYTE_W-1:0]    m_reply_byte,
    input logic                                  m_motor_valid,
    input logic signed [smcp_pkg::MOTOR_W-1:0]   m_motor_a,
    input logic signed [smcp_pkg::MOTOR_W-1:0]   m_motor_b
);
    import smcp_pkg::*;

    // no result is pending right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a reply byte and a motor update never share one result
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_reply_valid && m_motor_valid))
        else $error("reply and motor update in one result");

    // fields of an absent result read as zero
    a_zero_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_reply_valid || m_reply_byte == '0) &&
                    (m_motor_valid || (m_motor_a == '0 && m_motor_b == '0)))
        else $error("unused result field not zero");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reply_valid) &&
            $stable(m_reply_byte) && $stable(m_motor_valid) &&
            $stable(m_motor_a) && $stable(m_motor_b))
        else $error("stalled result changed");

endmodule

bind spi_motor_command_parser smcp_checker u_smcp_checker (.*);
